/* rtl/vtv_pkg.sv */
// ----------------------------------------------------------------------------
// vtv_pkg
// Shared types, constants and helpers for the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtv_pkg;

  localparam int CFG_REGS  = 8;
  localparam int CFG_SEL_W = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 64;

  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 256;

  localparam int NUM_W     = 48;
  localparam int DEN_W     = 32;
  localparam int DIV_STEPS = NUM_W;
  localparam int LANES     = 4;

  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic signed [65:0] S32_MAX_W = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN_W = -66'sd2147483648;

  localparam logic [NUM_W-1:0] IW_NUM = 48'h0001_0000_0000;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] u;
    logic [16:0] v;
    logic        sat;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] nq;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] lane;
    logic  [LANES-1:0] neg;
    logic  [LANES-1:0] nzero;
    logic  [DEN_W-1:0] den;
    logic              wzero;
    side_t             side;
  } dstage_t;

  typedef struct packed {
    logic [LANES-1:0][31:0] q;
    side_t                  side;
  } dout_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } sat_t;

  function automatic sat_t clamp_s32(logic signed [65:0] v);
    sat_t r;
    if (v > S32_MAX_W) begin
      r.sat = 1'b1;
      r.val = S32_MAX;
    end else if (v < S32_MIN_W) begin
      r.sat = 1'b1;
      r.val = S32_MIN;
    end else begin
      r.sat = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

  // one restoring division step
  function automatic lane_t div_step(lane_t l, logic [DEN_W-1:0] den);
    logic [DEN_W:0] trial;
    logic           ge;
    lane_t          r;
    trial = {l.rem, l.nq[NUM_W-1]};
    ge    = trial >= {1'b0, den};
    r.rem = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    r.nq  = {l.nq[NUM_W-2:0], ge};
    return r;
  endfunction

endpackage

/* rtl/vtv_in_if.sv */
// ----------------------------------------------------------------------------
// vtv_in_if
// Vertex request channel: position, color and texture coordinates.
// ----------------------------------------------------------------------------
interface vtv_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [7:0]         in_red;
  logic [7:0]         in_green;
  logic [7:0]         in_blue;
  logic [16:0]        in_u;
  logic [16:0]        in_v;

  modport source (output valid, pos_x, pos_y, pos_z, in_red, in_green, in_blue, in_u, in_v,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, in_red, in_green, in_blue, in_u, in_v,
                output ready);
endinterface

/* rtl/vtv_out_if.sv */
// ----------------------------------------------------------------------------
// vtv_out_if
// Transformed vertex channel: screen position, depth, 1/w and attributes.
// ----------------------------------------------------------------------------
interface vtv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] screen_x;
  logic signed [31:0] screen_y;
  logic signed [31:0] ndc_depth;
  logic signed [31:0] inverse_w;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic [16:0]        out_u;
  logic [16:0]        out_v;
  logic               saturated;

  modport source (output valid, screen_x, screen_y, ndc_depth, inverse_w, out_red, out_green,
                  out_blue, out_u, out_v, saturated, input ready);
  modport sink (input valid, screen_x, screen_y, ndc_depth, inverse_w, out_red, out_green,
                out_blue, out_u, out_v, saturated, output ready);
endinterface

/* rtl/vtv_div.sv */
// ----------------------------------------------------------------------------
// vtv_div
// Four-lane pipelined restoring divider, one quotient bit per stage, with a
// final stage that applies sign, zero-w handling and 32-bit saturation.
// ----------------------------------------------------------------------------
module vtv_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            in_vld_i,
  input  vtv_pkg::dstage_t in_i,
  output logic            out_vld_o,
  output vtv_pkg::dout_t  out_o
);
  import vtv_pkg::*;

  dstage_t              st_q [1:DIV_STEPS];
  logic [DIV_STEPS:1]   vld_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    dstage_t src;
    dstage_t nxt;
    logic    src_vld;

    if (k == 0) begin : g_first
      assign src     = in_i;
      assign src_vld = in_vld_i;
    end else begin : g_rest
      assign src     = st_q[k];
      assign src_vld = vld_q[k];
    end

    always_comb begin
      nxt = src;
      for (int l = 0; l < LANES; l++) begin
        nxt.lane[l] = div_step(src.lane[l], src.den);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= src_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  dstage_t last;
  dout_t   fix_d;
  assign last = st_q[DIV_STEPS];

  always_comb begin
    fix_d.side = last.side;
    for (int l = 0; l < LANES; l++) begin
      if (last.wzero) begin
        fix_d.side.sat = 1'b1;
        fix_d.q[l]     = last.nzero[l] ? 32'd0 : (last.neg[l] ? S32_MIN : S32_MAX);
      end else if (last.neg[l]) begin
        if (last.lane[l].nq > NUM_W'(S32_MIN)) begin
          fix_d.side.sat = 1'b1;
          fix_d.q[l]     = S32_MIN;
        end else begin
          fix_d.q[l] = 32'(-last.lane[l].nq);
        end
      end else begin
        if (last.lane[l].nq > NUM_W'(S32_MAX)) begin
          fix_d.side.sat = 1'b1;
          fix_d.q[l]     = S32_MAX;
        end else begin
          fix_d.q[l] = last.lane[l].nq[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_o <= 1'b0;
    end else if (adv_i) begin
      out_vld_o <= vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_o <= fix_d;
    end
  end

endmodule

/* rtl/vertex_transform_viewport_top.sv */
// ----------------------------------------------------------------------------
// vertex_transform_viewport_top
// Vertex transform by a 4x4 Q16.16 matrix, perspective divide and viewport
// mapping, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one vertex per clock and delivers one per clock while the output is
// not stalled; the pipeline from request to result is matrix multiply, row
// sum and clamp, divider setup, 48 single-bit divider stages shared by the x,
// y, z and 1/w lanes, quotient fixup, viewport multiply and the output
// register. A stall on the output holds the whole pipeline. The matrix may be
// rewritten only while no vertex is in flight.
module vertex_transform_viewport_top #(
  parameter int SCREEN_WIDTH  = vtv_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = vtv_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [vtv_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [vtv_pkg::CFG_W-1:0]      cfg_data_i,
  vtv_in_if.sink                         in_if,
  vtv_out_if.source                      out_if
);
  import vtv_pkg::*;

  localparam int WW = $clog2(SCREEN_WIDTH + 1);
  localparam int HW = $clog2(SCREEN_HEIGHT + 1);
  localparam int PXW = 33 + WW + 1;
  localparam int PYW = 33 + HW + 1;
  localparam logic signed [WW:0] SW_C = (WW+1)'(SCREEN_WIDTH);
  localparam logic signed [HW:0] SH_C = (HW+1)'(SCREEN_HEIGHT);

  logic [CFG_W-1:0] cfg_q [CFG_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[0] <= 64'h0000_0000_0001_0000;
      cfg_q[1] <= 64'h0;
      cfg_q[2] <= 64'h0001_0000_0000_0000;
      cfg_q[3] <= 64'h0;
      cfg_q[4] <= 64'h0;
      cfg_q[5] <= 64'h0000_0000_0001_0000;
      cfg_q[6] <= 64'h0;
      cfg_q[7] <= 64'h0001_0000_0000_0000;
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(CFG_REGS))) begin
      cfg_q[cfg_idx_i[CFG_SEL_W-1:0]] <= cfg_data_i;
    end
  end

  logic signed [31:0] m [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = cfg_q[2*r][31:0];
      m[r][1] = cfg_q[2*r][63:32];
      m[r][2] = cfg_q[2*r+1][31:0];
      m[r][3] = cfg_q[2*r+1][63:32];
    end
  end

  logic adv;
  logic out_vld_q;
  assign adv         = !out_vld_q || out_if.ready;
  assign in_if.ready = adv;

  // stage A: products
  logic               va_q;
  logic signed [63:0] prod_q [4][3];
  side_t              side_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        prod_q[r][0] <= in_if.pos_x * m[r][0];
        prod_q[r][1] <= in_if.pos_y * m[r][1];
        prod_q[r][2] <= in_if.pos_z * m[r][2];
      end
      side_a_q <= '{red: in_if.in_red, green: in_if.in_green, blue: in_if.in_blue,
                    u: in_if.in_u, v: in_if.in_v, sat: 1'b0};
    end
  end

  // stage B: row sums, clip clamp
  logic               vb_q;
  logic [31:0]        clip_q [4];
  side_t              side_b_q;
  side_t              side_b_d;
  logic signed [65:0] rsum [4];
  sat_t               rclamp [4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      rsum[r] = 66'(prod_q[r][0]) + 66'(prod_q[r][1]) + 66'(prod_q[r][2])
              + (66'(m[r][3]) <<< 16);
      rclamp[r] = clamp_s32(rsum[r] >>> 16);
    end
    side_b_d     = side_a_q;
    side_b_d.sat = rclamp[0].sat | rclamp[1].sat | rclamp[2].sat | rclamp[3].sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 4; r++) begin
        clip_q[r] <= rclamp[r].val;
      end
      side_b_q <= side_b_d;
    end
  end

  // stage C: divider setup
  logic    vc_q;
  dstage_t c_q;
  dstage_t c_d;
  logic    wneg;
  logic [31:0] amag [3];

  always_comb begin
    wneg      = clip_q[3][31];
    c_d.den   = wneg ? 32'(-clip_q[3]) : clip_q[3];
    c_d.wzero = clip_q[3] == 32'd0;
    c_d.side  = side_b_q;
    for (int r = 0; r < 3; r++) begin
      amag[r]             = clip_q[r][31] ? 32'(-clip_q[r]) : clip_q[r];
      c_d.lane[r].rem     = '0;
      c_d.lane[r].nq      = {amag[r], 16'd0};
      c_d.neg[r]          = clip_q[r][31] ^ wneg;
      c_d.nzero[r]        = clip_q[r] == 32'd0;
    end
    c_d.lane[3].rem = '0;
    c_d.lane[3].nq  = IW_NUM;
    c_d.neg[3]      = wneg;
    c_d.nzero[3]    = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_q <= c_d;
    end
  end

  logic  dv_vld;
  dout_t dv;

  vtv_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .in_vld_i (vc_q),
    .in_i     (c_q),
    .out_vld_o(dv_vld),
    .out_o    (dv)
  );

  // stage D2: viewport products
  logic                  vd2_q;
  logic signed [PXW-1:0] sxp_q;
  logic signed [PYW-1:0] syp_q;
  logic [31:0]           pz_q;
  logic [31:0]           iw_q;
  side_t                 side_d2_q;
  logic signed [32:0]    xs;
  logic signed [32:0]    ys;

  assign xs = 33'($signed(dv.q[0])) + 33'sd65536;
  assign ys = 33'sd65536 - 33'($signed(dv.q[1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd2_q <= 1'b0;
    end else if (adv) begin
      vd2_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sxp_q     <= PXW'(xs) * PXW'(SW_C);
      syp_q     <= PYW'(ys) * PYW'(SH_C);
      pz_q      <= dv.q[2];
      iw_q      <= dv.q[3];
      side_d2_q <= dv.side;
    end
  end

  // output register
  sat_t sx_c;
  sat_t sy_c;
  assign sx_c = clamp_s32(66'(sxp_q >>> 1));
  assign sy_c = clamp_s32(66'(syp_q >>> 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vd2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_if.screen_x  <= sx_c.val;
      out_if.screen_y  <= sy_c.val;
      out_if.ndc_depth <= pz_q;
      out_if.inverse_w <= iw_q;
      out_if.out_red   <= side_d2_q.red;
      out_if.out_green <= side_d2_q.green;
      out_if.out_blue  <= side_d2_q.blue;
      out_if.out_u     <= side_d2_q.u;
      out_if.out_v     <= side_d2_q.v;
      out_if.saturated <= side_d2_q.sat | sx_c.sat | sy_c.sat;
    end
  end

  assign out_if.valid = out_vld_q;

`ifndef NO_ASSERTIONS
  a_iw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.saturated |-> out_if.inverse_w != 32'sd0)
    else $error("inverse_w zero without saturation");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vd2_q) && $stable(dv_vld) && $stable(vc_q))
    else $error("pipeline valid moved during stall");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> va_q)
    else $error("accepted request not captured");

  a_zero_w_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q && c_q.wzero |-> c_q.den == '0 && !c_q.neg[3])
    else $error("zero w setup mismatch");
`endif

endmodule
